/* hw/rtl/nntb_pkg.sv */
package nntb_pkg;

    // Fixed field widths of the stream and register items
    localparam int CITY_W     = 6;
    localparam int WEIGHT_W   = 16;
    localparam int SUM_W      = 22;
    localparam int CC_W       = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam int MAX_CITIES_DEF = 64;

    // Register map: word index taken from paddr[2]
    localparam logic REG_CITY_COUNT = 1'b0;
    localparam logic [CC_W-1:0] CITY_COUNT_RST = 7'd64;

    // Input item kinds carried in tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_BUILD = 1'b1;

    // Sequencer steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT_FIRST,
        ST_SCAN_CLR,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_COMMIT,
        ST_EMIT_MID,
        ST_RET_READ,
        ST_RET_ADD,
        ST_EMIT_LAST
    } step_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_START,
        COND_OUT_FREE,
        COND_SCAN_END,
        COND_LAST_CITY
    } cond_t;

    // Result item kinds
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_FIRST,
        EMIT_MID,
        EMIT_LAST
    } emit_t;

    // Datapath operations of one control word
    typedef struct packed {
        logic  in_ready;
        logic  scan_clr;
        logic  scan_issue;
        logic  commit;
        logic  ret_read;
        logic  ret_add;
        emit_t emit;
    } uop_t;

    // Full control word
    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t go_true;
        step_t go_false;
    } ctrl_t;

    // Datapath status used by the jump logic
    typedef struct packed {
        logic start;
        logic out_free;
        logic scan_end;
        logic last_city;
    } stat_t;

    // Microcode table: one control word per step
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        w          = '0;
        w.uop.emit = EMIT_NONE;
        w.cond     = COND_ALWAYS;
        w.go_true  = ST_IDLE;
        w.go_false = ST_IDLE;
        case (step)
            ST_IDLE:
            begin
                w.uop.in_ready = 1'b1;
                w.cond         = COND_START;
                w.go_true      = ST_EMIT_FIRST;
                w.go_false     = ST_IDLE;
            end
            ST_EMIT_FIRST:
            begin
                w.uop.emit = EMIT_FIRST;
                w.cond     = COND_OUT_FREE;
                w.go_true  = ST_SCAN_CLR;
                w.go_false = ST_EMIT_FIRST;
            end
            ST_SCAN_CLR:
            begin
                w.uop.scan_clr = 1'b1;
                w.go_true      = ST_SCAN;
            end
            ST_SCAN:
            begin
                w.uop.scan_issue = 1'b1;
                w.cond           = COND_SCAN_END;
                w.go_true        = ST_SCAN_TAIL;
                w.go_false       = ST_SCAN;
            end
            ST_SCAN_TAIL:
            begin
                w.go_true = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                w.uop.commit = 1'b1;
                w.cond       = COND_LAST_CITY;
                w.go_true    = ST_RET_READ;
                w.go_false   = ST_EMIT_MID;
            end
            ST_EMIT_MID:
            begin
                w.uop.emit = EMIT_MID;
                w.cond     = COND_OUT_FREE;
                w.go_true  = ST_SCAN_CLR;
                w.go_false = ST_EMIT_MID;
            end
            ST_RET_READ:
            begin
                w.uop.ret_read = 1'b1;
                w.go_true      = ST_RET_ADD;
            end
            ST_RET_ADD:
            begin
                w.uop.ret_add = 1'b1;
                w.go_true     = ST_EMIT_LAST;
            end
            ST_EMIT_LAST:
            begin
                w.uop.emit = EMIT_LAST;
                w.cond     = COND_OUT_FREE;
                w.go_true  = ST_IDLE;
                w.go_false = ST_EMIT_LAST;
            end
            default:
            begin
                w.go_true  = ST_IDLE;
                w.go_false = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/nntb_mem.sv */
module nntb_mem #(
    parameter int MAX_CITIES = nntb_pkg::MAX_CITIES_DEF
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [2*$clog2(MAX_CITIES)-1:0]               wr_addr,
    input  logic [nntb_pkg::WEIGHT_W-1:0]                 wr_data,
    input  logic                                          rd_en,
    input  logic [2*$clog2(MAX_CITIES)-1:0]               rd_addr,
    output logic [nntb_pkg::WEIGHT_W-1:0]                 rd_data
);
    import nntb_pkg::*;

    localparam int IDX_W = $clog2(MAX_CITIES);
    localparam int DEPTH = MAX_CITIES << IDX_W;

    logic [WEIGHT_W-1:0] mem [DEPTH];
    logic [WEIGHT_W-1:0] rd_data_reg;

    // Write one weight per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/nntb_seq.sv */
module nntb_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  nntb_pkg::stat_t stat,
    output nntb_pkg::uop_t  uop
);
    import nntb_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    ctrl_t ctrl;
    logic  cond_hit;

    // Fetch the control word of the current step
    always_comb
    begin
        ctrl = ucode(pc_reg);
        uop  = ctrl.uop;
    end

    // Evaluate the jump condition and pick the next step
    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS:    cond_hit = 1'b1;
            COND_START:     cond_hit = stat.start;
            COND_OUT_FREE:  cond_hit = stat.out_free;
            COND_SCAN_END:  cond_hit = stat.scan_end;
            COND_LAST_CITY: cond_hit = stat.last_city;
            default:        cond_hit = 1'b1;
        endcase
        pc_next = cond_hit ? ctrl.go_true : ctrl.go_false;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* hw/rtl/nntb_dp.sv */
module nntb_dp #(
    parameter int MAX_CITIES = nntb_pkg::MAX_CITIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nntb_pkg::uop_t                      uop,
    output nntb_pkg::stat_t                     stat,
    input  logic [nntb_pkg::CC_W-1:0]           city_count,
    input  logic                                in_valid,
    input  logic                                in_action,
    input  logic [nntb_pkg::CITY_W-1:0]         in_from,
    input  logic [nntb_pkg::CITY_W-1:0]         in_to,
    input  logic [nntb_pkg::WEIGHT_W-1:0]       in_weight,
    output logic                                in_ready,
    output logic                                mem_wr_en,
    output logic [2*$clog2(MAX_CITIES)-1:0]     mem_wr_addr,
    output logic [nntb_pkg::WEIGHT_W-1:0]       mem_wr_data,
    output logic                                mem_rd_en,
    output logic [2*$clog2(MAX_CITIES)-1:0]     mem_rd_addr,
    input  logic [nntb_pkg::WEIGHT_W-1:0]       mem_rd_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [nntb_pkg::CITY_W-1:0]         out_position,
    output logic [nntb_pkg::CITY_W-1:0]         out_city,
    output logic [nntb_pkg::SUM_W-1:0]          out_tour_weight,
    output logic                                out_last
);
    import nntb_pkg::*;

    localparam int IDX_W = $clog2(MAX_CITIES);
    localparam int CNT_W = $clog2(MAX_CITIES + 1);

    logic                accept;
    logic                init;
    logic                emit_go;
    logic                take;
    logic [CNT_W-1:0]    n_clamp;
    logic [CNT_W-1:0]    n_m1;

    logic [CNT_W-1:0]    n_reg,         n_next;
    logic [IDX_W-1:0]    cur_reg,       cur_next;
    logic [IDX_W-1:0]    pos_reg,       pos_next;
    logic [IDX_W-1:0]    j_reg,         j_next;
    logic                vld_d_reg,     vld_d_next;
    logic                skip_d_reg,    skip_d_next;
    logic [IDX_W-1:0]    j_d_reg,       j_d_next;
    logic                found_reg,     found_next;
    logic [IDX_W-1:0]    best_city_reg, best_city_next;
    logic [WEIGHT_W-1:0] best_w_reg,    best_w_next;
    logic [SUM_W-1:0]    sum_reg,       sum_next;
    logic [MAX_CITIES-1:0] visited_reg, visited_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_pos_reg,   out_pos_next;
    logic [IDX_W-1:0]    out_city_reg,  out_city_next;
    logic [SUM_W-1:0]    out_sum_reg,   out_sum_next;
    logic                out_last_reg,  out_last_next;

    // Input handshake and item decode
    assign in_ready = uop.in_ready;
    assign accept   = uop.in_ready & in_valid;
    assign init     = accept & (in_action == ACT_BUILD);

    // Clamp the city count into its legal range
    always_comb
    begin
        if (city_count < CC_W'(2))
        begin
            n_clamp = CNT_W'(2);
        end
        else if (city_count > CC_W'(MAX_CITIES))
        begin
            n_clamp = CNT_W'(MAX_CITIES);
        end
        else
        begin
            n_clamp = CNT_W'(city_count);
        end
    end

    assign n_m1 = CNT_W'(n_reg - CNT_W'(1));

    // Matrix write for load items, dropped outside the matrix
    assign mem_wr_en   = accept & (in_action == ACT_LOAD)
                       & ((CC_W)'(in_from) < CC_W'(MAX_CITIES))
                       & ((CC_W)'(in_to) < CC_W'(MAX_CITIES));
    assign mem_wr_addr = {IDX_W'(in_from), IDX_W'(in_to)};
    assign mem_wr_data = in_weight;

    // Matrix read along the current row
    assign mem_rd_en   = uop.scan_issue | uop.ret_read;
    assign mem_rd_addr = uop.ret_read ? {cur_reg, IDX_W'(0)} : {cur_reg, j_reg};

    // Status for the sequencer
    assign emit_go        = !out_valid_reg || out_ready;
    assign stat.start     = init;
    assign stat.out_free  = emit_go;
    assign stat.scan_end  = CNT_W'(j_reg) == n_m1;
    assign stat.last_city = CNT_W'(pos_reg) == n_m1;

    // Compare the returned weight against the best so far; ties keep the lower index
    assign take = vld_d_reg && !skip_d_reg && (!found_reg || (mem_rd_data < best_w_reg));

    always_comb
    begin
        n_next         = n_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        j_next         = j_reg;
        vld_d_next     = 1'b0;
        skip_d_next    = skip_d_reg;
        j_d_next       = j_d_reg;
        found_next     = found_reg;
        best_city_next = best_city_reg;
        best_w_next    = best_w_reg;
        sum_next       = sum_reg;
        visited_next   = visited_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_city_next  = out_city_reg;
        out_sum_next   = out_sum_reg;
        out_last_next  = out_last_reg;

        // Start a tour at city zero
        if (init)
        begin
            n_next       = n_clamp;
            cur_next     = '0;
            pos_next     = IDX_W'(1);
            sum_next     = '0;
            visited_next = MAX_CITIES'(1);
        end

        // Reset the row scan
        if (uop.scan_clr)
        begin
            j_next     = '0;
            found_next = 1'b0;
        end

        // Issue one read per cycle and tag it
        if (uop.scan_issue)
        begin
            vld_d_next  = 1'b1;
            skip_d_next = visited_reg[j_reg];
            j_d_next    = j_reg;
            j_next      = IDX_W'(j_reg + 1'b1);
        end

        if (take)
        begin
            found_next     = 1'b1;
            best_city_next = j_d_reg;
            best_w_next    = mem_rd_data;
        end

        // Move to the chosen city
        if (uop.commit)
        begin
            cur_next                = best_city_reg;
            visited_next[best_city_reg] = 1'b1;
            sum_next                = SUM_W'(sum_reg + SUM_W'(best_w_reg));
        end

        // Close the tour with the edge back to city zero
        if (uop.ret_add)
        begin
            sum_next = SUM_W'(sum_reg + SUM_W'(mem_rd_data));
        end

        // Drop a taken result
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Load the output register
        if (emit_go)
        begin
            case (uop.emit)
                EMIT_FIRST:
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = '0;
                    out_city_next  = '0;
                    out_sum_next   = '0;
                    out_last_next  = 1'b0;
                end
                EMIT_MID:
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_city_next  = cur_reg;
                    out_sum_next   = '0;
                    out_last_next  = 1'b0;
                    pos_next       = IDX_W'(pos_reg + 1'b1);
                end
                EMIT_LAST:
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_city_next  = cur_reg;
                    out_sum_next   = sum_reg;
                    out_last_next  = 1'b1;
                end
                default:
                begin
                    out_valid_next = out_valid_next;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CNT_W'(MAX_CITIES);
            cur_reg       <= '0;
            pos_reg       <= '0;
            j_reg         <= '0;
            vld_d_reg     <= 1'b0;
            found_reg     <= 1'b0;
            sum_reg       <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            j_reg         <= j_next;
            vld_d_reg     <= vld_d_next;
            found_reg     <= found_next;
            sum_reg       <= sum_next;
            visited_reg   <= visited_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        skip_d_reg    <= skip_d_next;
        j_d_reg       <= j_d_next;
        best_city_reg <= best_city_next;
        best_w_reg    <= best_w_next;
        out_pos_reg   <= out_pos_next;
        out_city_reg  <= out_city_next;
        out_sum_reg   <= out_sum_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_position    = CITY_W'(out_pos_reg);
    assign out_city        = CITY_W'(out_city_reg);
    assign out_tour_weight = out_sum_reg;
    assign out_last        = out_last_reg;

endmodule

/* hw/rtl/nearest_neighbour_tour_builder_top.sv */
// Load item: one matrix weight per item, accepted back to back at one item per cycle while
// no build is in progress. Build item: the single weight-memory read port scans one row
// entry per cycle; a result is emitted after each row scan, and a stalled result holds
// the sequencer until it is taken. No new item is accepted until the last result is
// loaded. Reset (rst_n, async, active low) clears control state and sets city_count to
// 64; the weight matrix is not cleared.
module nearest_neighbour_tour_builder_top #(
    parameter int MAX_CITIES = nntb_pkg::MAX_CITIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] from_city, [11:6] to_city, [27:12] edge_weight, [31:28] zero
    input  logic [nntb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] action
    input  logic                                s_axis_tuser,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [5:0] position, [11:6] city, [33:12] tour_weight, [39:34] zero
    output logic [nntb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    // Register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nntb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nntb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nntb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import nntb_pkg::*;

    localparam int IDX_W = $clog2(MAX_CITIES);

    logic [CC_W-1:0]     city_count_reg;
    logic [CC_W-1:0]     city_count_next;
    logic                cc_wr;
    uop_t                uop;
    stat_t               stat;
    logic                mem_wr_en;
    logic [2*IDX_W-1:0]  mem_wr_addr;
    logic [WEIGHT_W-1:0] mem_wr_data;
    logic                mem_rd_en;
    logic [2*IDX_W-1:0]  mem_rd_addr;
    logic [WEIGHT_W-1:0] mem_rd_data;
    logic [CITY_W-1:0]   out_position;
    logic [CITY_W-1:0]   out_city;
    logic [SUM_W-1:0]    out_tour_weight;

    // Register write and read
    assign pready          = 1'b1;
    assign cc_wr           = psel & penable & pwrite & pready & (paddr[2] == REG_CITY_COUNT);
    assign city_count_next = cc_wr ? pwdata[CC_W-1:0] : city_count_reg;
    assign prdata          = (paddr[2] == REG_CITY_COUNT) ? APB_DATA_W'(city_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= CITY_COUNT_RST;
        end
        else
        begin
            city_count_reg <= city_count_next;
        end
    end

    nntb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .uop   (uop)
    );

    nntb_mem #(
        .MAX_CITIES (MAX_CITIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    nntb_dp #(
        .MAX_CITIES (MAX_CITIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .uop             (uop),
        .stat            (stat),
        .city_count      (city_count_reg),
        .in_valid        (s_axis_tvalid),
        .in_action       (s_axis_tuser),
        .in_from         (s_axis_tdata[5:0]),
        .in_to           (s_axis_tdata[11:6]),
        .in_weight       (s_axis_tdata[27:12]),
        .in_ready        (s_axis_tready),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_position    (out_position),
        .out_city        (out_city),
        .out_tour_weight (out_tour_weight),
        .out_last        (m_axis_tlast)
    );

    // Pack the result item
    assign m_axis_tdata = {6'b0, out_tour_weight, out_city, out_position};

endmodule
